### hdl/fel_pkg.sv
package fel_pkg;

  // Volume type, as it appears on the fat_kind port.
  typedef enum logic [1:0] {
    KIND_FAT12 = 2'd0,
    KIND_FAT16 = 2'd1,
    KIND_FAT32 = 2'd2
  } fat_kind_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_BYTES_PER_SECTOR    = 3'd0;
  localparam logic [2:0] REG_SECTORS_PER_CLUSTER = 3'd1;
  localparam logic [2:0] REG_RESERVED_SECTORS    = 3'd2;
  localparam logic [2:0] REG_FAT_COUNT           = 3'd3;
  localparam logic [2:0] REG_ROOT_ENTRIES        = 3'd4;
  localparam logic [2:0] REG_FAT_SIZE_SHORT      = 3'd5;
  localparam logic [2:0] REG_FAT_SIZE_LONG       = 3'd6;
  localparam logic [2:0] REG_TOTAL_SECTORS       = 3'd7;

  // Cluster count limits that pick the volume type.
  localparam logic [11:0] FAT12_MAX_CLUSTERS = 12'd4085;
  localparam logic [15:0] FAT16_MAX_CLUSTERS = 16'd65525;

  // End-of-chain thresholds and marks, and bad-cluster marks.
  localparam logic [27:0] EOC_THR_FAT12 = 28'h0000FF8;
  localparam logic [27:0] EOC_THR_FAT16 = 28'h000FFF8;
  localparam logic [27:0] EOC_THR_FAT32 = 28'hFFFFFF8;
  localparam logic [27:0] EOC_FAT12     = 28'h0000FFF;
  localparam logic [27:0] EOC_FAT16     = 28'h000FFFF;
  localparam logic [27:0] EOC_FAT32     = 28'hFFFFFFF;
  localparam logic [27:0] BAD_FAT12     = 28'h0000FF7;
  localparam logic [27:0] BAD_FAT16     = 28'h000FFF7;
  localparam logic [27:0] BAD_FAT32     = 28'hFFFFFF7;

  typedef struct packed {
    logic [12:0] bytes_per_sector;
    logic [7:0]  sectors_per_cluster;
    logic [15:0] reserved_sectors;
    logic [2:0]  fat_count;
    logic [15:0] root_entries;
    logic [15:0] fat_size_short;
    logic [31:0] fat_size_long;
    logic [31:0] total_sectors;
  } cfg_t;

endpackage

### hdl/fel_cfg.sv
module fel_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output fel_pkg::cfg_t      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bytes_per_sector    <= 13'd512;
      cfg.sectors_per_cluster <= 8'd4;
      cfg.reserved_sectors    <= 16'd1;
      cfg.fat_count           <= 3'd2;
      cfg.root_entries        <= 16'd512;
      cfg.fat_size_short      <= 16'd0;
      cfg.fat_size_long       <= 32'd0;
      cfg.total_sectors       <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        fel_pkg::REG_BYTES_PER_SECTOR:    cfg.bytes_per_sector    <= cfg_data[12:0];
        fel_pkg::REG_SECTORS_PER_CLUSTER: cfg.sectors_per_cluster <= cfg_data[7:0];
        fel_pkg::REG_RESERVED_SECTORS:    cfg.reserved_sectors    <= cfg_data[15:0];
        fel_pkg::REG_FAT_COUNT:           cfg.fat_count           <= cfg_data[2:0];
        fel_pkg::REG_ROOT_ENTRIES:        cfg.root_entries        <= cfg_data[15:0];
        fel_pkg::REG_FAT_SIZE_SHORT:      cfg.fat_size_short      <= cfg_data[15:0];
        fel_pkg::REG_FAT_SIZE_LONG:       cfg.fat_size_long       <= cfg_data;
        fel_pkg::REG_TOTAL_SECTORS:       cfg.total_sectors       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

### hdl/fel_div.sv
// Pipelined restoring divider: STEPS quotient bits per stage. The caller
// handles a zero divisor, for which the results here mean nothing.
module fel_div #(
  parameter int DW    = 22,
  parameter int VW    = 13,
  parameter int SW    = 8,
  parameter int STEPS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder,
  output logic [SW-1:0] side_out
);

  localparam int NSTG = (DW + STEPS - 1) / STEPS;

  logic [NSTG:0] vld;
  logic [VW-1:0] rem  [NSTG+1];
  logic [DW-1:0] work [NSTG+1];
  logic [SW-1:0] side [NSTG+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign work[0] = dividend;
  assign side[0] = side_in;

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    logic [VW:0]   t;
    logic [VW-1:0] r_c;
    logic [DW-1:0] w_c;

    always_comb begin
      t   = '0;
      r_c = rem[s];
      w_c = work[s];
      for (int k = 0; k < STEPS; k++) begin
        if (s * STEPS + k < DW) begin
          t   = {r_c, w_c[DW-1]};
          w_c = {w_c[DW-2:0], 1'b0};
          if (t >= {1'b0, divisor}) begin
            t      = t - {1'b0, divisor};
            w_c[0] = 1'b1;
          end
          r_c = t[VW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      rem[s+1]  <= r_c;
      work[s+1] <= w_c;
      side[s+1] <= side[s];
    end
  end

  assign out_valid = vld[NSTG];
  assign quotient  = work[NSTG];
  assign remainder = rem[NSTG];
  assign side_out  = side[NSTG];

endmodule

### hdl/fat_entry_locator.sv
// FAT entry locator. Each transfer on start/cluster_index/fat_copy/
// entry_value yields exactly one result, shown on the result ports for one
// cycle while done is high; the receiver cannot hold results off, so it
// must take every done cycle. busy is never raised: a new item may be
// started in every cycle, and results come back in start order. The
// pipeline holds two pipelined dividers by bytes_per_sector: one for the
// root directory sector count, one for the entry's sector and byte
// offset. Configuration registers are read directly by every pipeline
// stage, so they must only be written while no item is in flight.
module fat_entry_locator #(
  parameter int DIV_STEPS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [27:0] cluster_index,
  input  logic [1:0]  fat_copy,
  input  logic [27:0] entry_value,
  output logic        done,
  output logic [1:0]  fat_kind,
  output logic [31:0] entry_sector,
  output logic [11:0] entry_offset,
  output logic        odd_entry,
  output logic        spans_boundary,
  output logic [31:0] cluster_start_sector,
  output logic        chain_end,
  output logic [27:0] end_mark,
  output logic [27:0] bad_mark
);

  fel_pkg::cfg_t cfg;

  fel_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign busy = 1'b0;

  // Values that depend on the configuration alone.
  logic [31:0] fatsz;
  logic        bps_zero;
  logic [21:0] root_bytes;
  logic [34:0] fat_region;
  logic [19:0] thr12;
  logic [23:0] thr16;

  assign fatsz      = (cfg.fat_size_short != 16'd0) ? {16'd0, cfg.fat_size_short}
                                                     : cfg.fat_size_long;
  assign bps_zero   = (cfg.bytes_per_sector == 13'd0);
  // Root directory bytes, rounded up by the sector size minus one.
  assign root_bytes = {1'b0, cfg.root_entries, 5'd0} + {9'd0, cfg.bytes_per_sector}
                      - 22'd1;
  assign fat_region = 35'(cfg.fat_count) * 35'(fatsz);
  // The cluster count is compared against the type limits by scaling the
  // limits by the cluster size instead of dividing the data sector count.
  assign thr12      = 20'(fel_pkg::FAT12_MAX_CLUSTERS) * 20'(cfg.sectors_per_cluster);
  assign thr16      = 24'(fel_pkg::FAT16_MAX_CLUSTERS) * 24'(cfg.sectors_per_cluster);

  // Divider A: root directory sectors. The item rides along as sideband.
  localparam int SA = 58;
  logic          a_valid;
  logic [21:0]   a_q;
  logic [12:0]   a_r;
  logic [SA-1:0] a_side;

  fel_div #(.DW(22), .VW(13), .SW(SA), .STEPS(DIV_STEPS)) u_div_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .dividend  (root_bytes),
    .divisor   (cfg.bytes_per_sector),
    .side_in   ({cluster_index, fat_copy, entry_value}),
    .out_valid (a_valid),
    .quotient  (a_q),
    .remainder (a_r),
    .side_out  (a_side)
  );

  // Stage 1: first data sector and the cluster's offset into the data area.
  logic        s1_valid;
  logic [34:0] s1_first_data;
  logic [31:0] s1_clus_off;
  logic [27:0] s1_n;
  logic [1:0]  s1_copy;
  logic [27:0] s1_val;
  logic [21:0] root_secs;
  logic [31:0] n_minus2;

  assign root_secs = bps_zero ? 22'd0 : a_q;
  assign n_minus2  = {4'd0, a_side[57:30]} - 32'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_data <= {19'd0, cfg.reserved_sectors} + fat_region + {13'd0, root_secs};
    s1_clus_off   <= 32'(n_minus2 * 32'(cfg.sectors_per_cluster));
    s1_n          <= a_side[57:30];
    s1_copy       <= a_side[29:28];
    s1_val        <= a_side[27:0];
  end

  // Stage 2: data sectors, volume type and the cluster's start sector.
  logic              s2_valid;
  fel_pkg::fat_kind_t s2_kind;
  logic [31:0]       s2_cluster_start;
  logic [27:0]       s2_n;
  logic [1:0]        s2_copy;
  logic [27:0]       s2_val;
  logic [31:0]       data_secs;
  fel_pkg::fat_kind_t kind_next;

  always_comb begin
    if ({3'd0, cfg.total_sectors} > s1_first_data) begin
      data_secs = cfg.total_sectors - s1_first_data[31:0];
    end else begin
      data_secs = 32'd0;
    end
    // A zero cluster size gives a cluster count of zero, so FAT12.
    if (cfg.sectors_per_cluster == 8'd0 || data_secs < {12'd0, thr12}) begin
      kind_next = fel_pkg::KIND_FAT12;
    end else if (data_secs < {8'd0, thr16}) begin
      kind_next = fel_pkg::KIND_FAT16;
    end else begin
      kind_next = fel_pkg::KIND_FAT32;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_kind          <= kind_next;
    s2_cluster_start <= s1_clus_off + s1_first_data[31:0];
    s2_n             <= s1_n;
    s2_copy          <= s1_copy;
    s2_val           <= s1_val;
  end

  // Byte offset of the entry in its FAT: 1.5, 2 or 4 bytes per cluster.
  logic [29:0] byte_off;

  always_comb begin
    case (s2_kind)
      fel_pkg::KIND_FAT12: byte_off = {2'd0, s2_n} + {3'd0, s2_n[27:1]};
      fel_pkg::KIND_FAT16: byte_off = {1'b0, s2_n, 1'b0};
      fel_pkg::KIND_FAT32: byte_off = {s2_n, 2'b00};
      default:             byte_off = {2'd0, s2_n};
    endcase
  end

  // Divider B: sector and byte offset of the entry.
  localparam int SB = 95;
  logic          b_valid;
  logic [29:0]   b_q;
  logic [12:0]   b_r;
  logic [SB-1:0] b_side;

  fel_div #(.DW(30), .VW(13), .SW(SB), .STEPS(DIV_STEPS)) u_div_entry (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .dividend  (byte_off),
    .divisor   (cfg.bytes_per_sector),
    .side_in   ({s2_kind, s2_n[0], s2_copy, s2_val, s2_cluster_start, byte_off}),
    .out_valid (b_valid),
    .quotient  (b_q),
    .remainder (b_r),
    .side_out  (b_side)
  );

  // Output stage.
  fel_pkg::fat_kind_t o_kind;
  logic              o_n0;
  logic [1:0]        o_copy;
  logic [27:0]       o_val;
  logic [31:0]       o_cs;
  logic [29:0]       o_boff;
  logic [29:0]       o_q;
  logic [11:0]       o_off;
  logic              o_span;
  logic              o_fat12;

  assign o_kind  = fel_pkg::fat_kind_t'(b_side[94:93]);
  assign o_n0    = b_side[92];
  assign o_copy  = b_side[91:90];
  assign o_val   = b_side[89:62];
  assign o_cs    = b_side[61:30];
  assign o_boff  = b_side[29:0];
  assign o_fat12 = (o_kind == fel_pkg::KIND_FAT12);

  // A zero sector size leaves the quotient at zero and the whole byte
  // offset as the remainder.
  assign o_q    = bps_zero ? 30'd0 : b_q;
  assign o_off  = bps_zero ? o_boff[11:0] : b_r[11:0];
  assign o_span = o_fat12 && !bps_zero && (b_r == cfg.bytes_per_sector - 13'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    fat_kind             <= o_kind;
    entry_sector         <= 32'({2'd0, o_copy} * fatsz) + {16'd0, cfg.reserved_sectors}
                            + {2'd0, o_q};
    entry_offset         <= o_off;
    odd_entry            <= o_fat12 && o_n0;
    spans_boundary       <= o_span;
    cluster_start_sector <= o_cs;
    case (o_kind)
      fel_pkg::KIND_FAT12: begin
        chain_end <= (o_val >= fel_pkg::EOC_THR_FAT12);
        end_mark  <= fel_pkg::EOC_FAT12;
        bad_mark  <= fel_pkg::BAD_FAT12;
      end
      fel_pkg::KIND_FAT16: begin
        chain_end <= (o_val >= fel_pkg::EOC_THR_FAT16);
        end_mark  <= fel_pkg::EOC_FAT16;
        bad_mark  <= fel_pkg::BAD_FAT16;
      end
      default: begin
        chain_end <= (o_val >= fel_pkg::EOC_THR_FAT32);
        end_mark  <= fel_pkg::EOC_FAT32;
        bad_mark  <= fel_pkg::BAD_FAT32;
      end
    endcase
  end

endmodule

### hdl/fel_checker.sv
module fel_checker (
  input logic        clk,
  input logic        rst,
  input logic        done,
  input logic [1:0]  fat_kind,
  input logic        odd_entry,
  input logic        spans_boundary,
  input logic [27:0] end_mark,
  input logic [27:0] bad_mark
);

  // No result may appear in the cycle after reset.
  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (fat_kind == fel_pkg::KIND_FAT12 || fat_kind == fel_pkg::KIND_FAT16 ||
              fat_kind == fel_pkg::KIND_FAT32))
    else $error("illegal volume type");

  // Odd and straddling entries exist only on FAT12.
  a_fat12_flags: assert property (@(posedge clk) disable iff (rst)
    done && fat_kind != fel_pkg::KIND_FAT12 |-> !odd_entry && !spans_boundary)
    else $error("FAT12 flag on a wider FAT");

  a_marks_match_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> end_mark == bad_mark + 28'd8 &&
             ((fat_kind == fel_pkg::KIND_FAT12 && end_mark == fel_pkg::EOC_FAT12) ||
              (fat_kind == fel_pkg::KIND_FAT16 && end_mark == fel_pkg::EOC_FAT16) ||
              (fat_kind == fel_pkg::KIND_FAT32 && end_mark == fel_pkg::EOC_FAT32)))
    else $error("chain marks do not match volume type");

endmodule

bind fat_entry_locator fel_checker u_fel_checker (
  .clk            (clk),
  .rst            (rst),
  .done           (done),
  .fat_kind       (fat_kind),
  .odd_entry      (odd_entry),
  .spans_boundary (spans_boundary),
  .end_mark       (end_mark),
  .bad_mark       (bad_mark)
);

### verif/tb_fat_entry_locator.sv
// Testbench for fat_entry_locator.
//
// Lookups are driven on the start handshake with random gaps, and every
// done cycle is taken as one result transfer. A behavioral calculator of
// the FAT geometry predicts each result at the moment its input transfer
// is accepted, and pushes it onto a queue of pending lookups. Results come
// back in order, so each result is compared field by field with the head
// of that queue.
//
// The run walks through several volume geometries: the reset geometry,
// FAT12, FAT16 and FAT32 sized volumes, a volume whose metadata overruns
// its total size, zero sector size and zero cluster size, and an 8191-byte
// sector with offsets past 4095. Registers are only written when the
// pending queue is empty and the pipeline has drained.
module tb_fat_entry_locator;

  localparam int LATENCY   = 10;
  localparam int MAX_CYCLES = 400000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        start;
  logic        busy;
  logic [27:0] cluster_index;
  logic [1:0]  fat_copy;
  logic [27:0] entry_value;
  logic        done;
  logic [1:0]  fat_kind;
  logic [31:0] entry_sector;
  logic [11:0] entry_offset;
  logic        odd_entry;
  logic        spans_boundary;
  logic [31:0] cluster_start_sector;
  logic        chain_end;
  logic [27:0] end_mark;
  logic [27:0] bad_mark;

  fat_entry_locator dut (.*);

  // One predicted lookup result.
  typedef struct packed {
    fel_pkg::fat_kind_t kind;
    logic [31:0]        sector;
    logic [11:0]        offset;
    logic               odd;
    logic               span;
    logic [31:0]        first_sector;
    logic               eoc;
    logic [27:0]        eoc_mark;
    logic [27:0]        bad;
  } lookup_t;

  // One directed row; has_known says whether want holds a typed-in result.
  typedef struct {
    logic [27:0] cl;
    logic [1:0]  cp;
    logic [27:0] val;
    bit          has_known;
    lookup_t     want;
  } row_t;

  fel_pkg::cfg_t geom;    // the testbench's copy of the registers
  lookup_t       pending[$];
  int            mismatches;
  int            cycles;
  int            seen;

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // Runaway guard; the slowest correct run is far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("FAIL fat_entry_locator");
      $finish;
    end
  end

  // Division with the block's rule for a zero divisor.
  function automatic logic [63:0] quot(logic [63:0] a, logic [63:0] b);
    return (b == 64'd0) ? 64'd0 : a / b;
  endfunction

  function automatic logic [63:0] remd(logic [63:0] a, logic [63:0] b);
    return (b == 64'd0) ? a : a % b;
  endfunction

  // Geometry calculation for one lookup under the current registers.
  function automatic lookup_t locate(logic [27:0] cl, logic [1:0] cp, logic [27:0] val);
    logic [63:0] bps, fatsz, root_secs, first_data, data_secs, clusters, boff, in_sec;
    logic [63:0] n, thr, tot;
    lookup_t r;
    n = 64'(cl);
    bps = 64'(geom.bytes_per_sector);
    fatsz = (geom.fat_size_short != 16'd0) ? 64'(geom.fat_size_short)
                                            : 64'(geom.fat_size_long);
    root_secs = quot(64'(geom.root_entries) * 64'd32 + bps - 64'd1, bps);
    first_data = 64'(geom.reserved_sectors) + 64'(geom.fat_count) * fatsz + root_secs;
    tot = 64'(geom.total_sectors);
    data_secs = (tot > first_data) ? tot - first_data : 64'd0;
    clusters = quot(data_secs, 64'(geom.sectors_per_cluster));
    r = '0;
    if (clusters < 64'(fel_pkg::FAT12_MAX_CLUSTERS)) begin
      r.kind = fel_pkg::KIND_FAT12;
      boff = n + (n >> 1);
      thr = 64'(fel_pkg::EOC_THR_FAT12);
      r.eoc_mark = fel_pkg::EOC_FAT12; r.bad = fel_pkg::BAD_FAT12;
    end else if (clusters < 64'(fel_pkg::FAT16_MAX_CLUSTERS)) begin
      r.kind = fel_pkg::KIND_FAT16;
      boff = n * 64'd2;
      thr = 64'(fel_pkg::EOC_THR_FAT16);
      r.eoc_mark = fel_pkg::EOC_FAT16; r.bad = fel_pkg::BAD_FAT16;
    end else begin
      r.kind = fel_pkg::KIND_FAT32;
      boff = n * 64'd4;
      thr = 64'(fel_pkg::EOC_THR_FAT32);
      r.eoc_mark = fel_pkg::EOC_FAT32; r.bad = fel_pkg::BAD_FAT32;
    end
    in_sec = remd(boff, bps);
    if (r.kind == fel_pkg::KIND_FAT12) begin
      r.odd = n[0];
      r.span = (bps != 64'd0) && (in_sec == bps - 64'd1);
    end
    r.sector = 32'(64'(cp) * fatsz + 64'(geom.reserved_sectors) + quot(boff, bps));
    r.offset = in_sec[11:0];
    r.first_sector = 32'((n - 64'd2) * 64'(geom.sectors_per_cluster) + first_data);
    r.eoc = (64'(val) >= thr);
    return r;
  endfunction

  // Result side: every done cycle is one transfer to check.
  always @(posedge clk) begin
    lookup_t got, exp_r;
    if (!rst && done) begin
      got.kind = fel_pkg::fat_kind_t'(fat_kind);
      got.sector = entry_sector;
      got.offset = entry_offset;
      got.odd = odd_entry;
      got.span = spans_boundary;
      got.first_sector = cluster_start_sector;
      got.eoc = chain_end;
      got.eoc_mark = end_mark;
      got.bad = bad_mark;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %p", got);
      end else begin
        exp_r = pending.pop_front();
        seen++;
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: expected %p actual %p", seen, exp_r, got);
        end
      end
    end
  end

  // Waits for every pending result, then lets the pipeline drain.
  task automatic drain();
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Writes one register; the caller drops the write enable after the last one.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      fel_pkg::REG_BYTES_PER_SECTOR:    geom.bytes_per_sector = data[12:0];
      fel_pkg::REG_SECTORS_PER_CLUSTER: geom.sectors_per_cluster = data[7:0];
      fel_pkg::REG_RESERVED_SECTORS:    geom.reserved_sectors = data[15:0];
      fel_pkg::REG_FAT_COUNT:           geom.fat_count = data[2:0];
      fel_pkg::REG_ROOT_ENTRIES:        geom.root_entries = data[15:0];
      fel_pkg::REG_FAT_SIZE_SHORT:      geom.fat_size_short = data[15:0];
      fel_pkg::REG_FAT_SIZE_LONG:       geom.fat_size_long = data;
      fel_pkg::REG_TOTAL_SECTORS:       geom.total_sectors = data;
      default: begin
      end
    endcase
  endtask

  // Loads a whole geometry; the pipeline must be empty.
  task automatic set_geometry(logic [31:0] bps, logic [31:0] spc, logic [31:0] rsv,
                              logic [31:0] nfat, logic [31:0] root, logic [31:0] fs16,
                              logic [31:0] fs32, logic [31:0] tot);
    drain();
    write_reg(fel_pkg::REG_BYTES_PER_SECTOR, bps);
    write_reg(fel_pkg::REG_SECTORS_PER_CLUSTER, spc);
    write_reg(fel_pkg::REG_RESERVED_SECTORS, rsv);
    write_reg(fel_pkg::REG_FAT_COUNT, nfat);
    write_reg(fel_pkg::REG_ROOT_ENTRIES, root);
    write_reg(fel_pkg::REG_FAT_SIZE_SHORT, fs16);
    write_reg(fel_pkg::REG_FAT_SIZE_LONG, fs32);
    write_reg(fel_pkg::REG_TOTAL_SECTORS, tot);
    cfg_we <= 1'b0;
  endtask

  // Random gap before a transfer: mostly none or short, a few long.
  task automatic idle_gap(bit bursty);
    int g;
    g = int'($urandom_range(0, 99));
    if (bursty || g < 55) return;
    start <= 1'b0;
    if (g < 95) repeat ($urandom_range(1, 3)) @(posedge clk);
    else repeat ($urandom_range(8, 40)) @(posedge clk);
  endtask

  // Drives one lookup and records its prediction on acceptance. start stays
  // high afterwards so that the next lookup can follow without a gap.
  task automatic issue(logic [27:0] cl, logic [1:0] cp, logic [27:0] val, bit bursty);
    idle_gap(bursty);
    start <= 1'b1;
    cluster_index <= cl;
    fat_copy <= cp;
    entry_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending.push_back(locate(cl, cp, val));
  endtask

  // Cluster numbers: mostly small, with edge values mixed in.
  function automatic logic [27:0] pick_cluster();
    case ($urandom_range(0, 7))
      0:       return 28'($urandom_range(0, 3));
      1:       return 28'hFFFFFFF - 28'($urandom_range(0, 3));
      2, 3:    return 28'($urandom());
      default: return 28'($urandom_range(2, 70000));
    endcase
  endfunction

  // Entry values concentrated around the end-of-chain thresholds.
  function automatic logic [27:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return fel_pkg::EOC_THR_FAT12 - 28'd4 + 28'($urandom_range(0, 11));
      1:       return fel_pkg::EOC_THR_FAT16 - 28'd4 + 28'($urandom_range(0, 11));
      2:       return fel_pkg::EOC_THR_FAT32 - 28'd4 + 28'($urandom_range(0, 11));
      default: return 28'($urandom());
    endcase
  endfunction

  task automatic random_batch(int count);
    bit bursty;
    bursty = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) bursty = ($urandom_range(0, 3) == 0);
      issue(pick_cluster(), 2'($urandom()), pick_value(), bursty);
      // Now and then hold the sender until every result is back.
      if ($urandom_range(0, 199) == 0 && pending.size() != 0) begin
        start <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
      end
    end
  endtask

  row_t rows[$];

  function automatic row_t mk(logic [27:0] cl, logic [1:0] cp, logic [27:0] val);
    row_t r;
    r.cl = cl; r.cp = cp; r.val = val; r.has_known = 1'b0; r.want = '0;
    return r;
  endfunction

  initial begin
    row_t r;
    lookup_t exp_r;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = fel_pkg::REG_BYTES_PER_SECTOR;
    cfg_data = '0;
    start = 1'b0;
    cluster_index = '0;
    fat_copy = '0;
    entry_value = '0;
    cycles = 0;
    mismatches = 0;
    seen = 0;
    geom = '{bytes_per_sector: 13'd512, sectors_per_cluster: 8'd4, reserved_sectors: 16'd1,
             fat_count: 3'd2, root_entries: 16'd512, fat_size_short: 16'd0,
             fat_size_long: 32'd0, total_sectors: 32'd0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset the volume has no sectors: FAT12, 512-byte sectors, first
    // data sector 1 + 0 + 32 = 33. Cluster 2 sits at byte 3 of sector 1.
    r = mk(28'd2, 2'd0, 28'd0);
    r.has_known = 1'b1;
    r.want = '{kind: fel_pkg::KIND_FAT12, sector: 32'd1, offset: 12'd3, odd: 1'b0,
               span: 1'b0, first_sector: 32'd33, eoc: 1'b0,
               eoc_mark: fel_pkg::EOC_FAT12, bad: fel_pkg::BAD_FAT12};
    rows.push_back(r);
    // Cluster 341 ends at byte 511, so its entry straddles the sector.
    r = mk(28'd341, 2'd3, fel_pkg::EOC_THR_FAT12);
    r.has_known = 1'b1;
    r.want = '{kind: fel_pkg::KIND_FAT12, sector: 32'd1, offset: 12'd511, odd: 1'b1,
               span: 1'b1, first_sector: 32'd1389, eoc: 1'b1,
               eoc_mark: fel_pkg::EOC_FAT12, bad: fel_pkg::BAD_FAT12};
    rows.push_back(r);
    // Clusters 0 and 1 wrap the start sector.
    rows.push_back(mk(28'd0, 2'd0, 28'd0));
    rows.push_back(mk(28'd1, 2'd1, fel_pkg::EOC_THR_FAT12 - 28'd1));
    rows.push_back(mk(28'hFFFFFFF, 2'd2, 28'hFFFFFFF));
    rows.push_back(mk(28'h5555555, 2'd1, 28'hAAAAAAA));
    rows.push_back(mk(28'hAAAAAAA, 2'd2, 28'h5555555));
    foreach (rows[i]) begin
      issue(rows[i].cl, rows[i].cp, rows[i].val, 1'b1);
      if (rows[i].has_known) begin
        exp_r = pending[pending.size() - 1];
        if (exp_r !== rows[i].want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed row %0d: calculator %p, table %p", i, exp_r, rows[i].want);
        end
      end
    end
    random_batch(150);

    // FAT16 volume, several copies, one beyond the count.
    set_geometry(512, 4, 4, 2, 512, 200, 0, 200000);
    rows = {};
    rows.push_back(mk(28'd2, 2'd3, fel_pkg::EOC_THR_FAT16));
    rows.push_back(mk(28'd255, 2'd1, fel_pkg::EOC_THR_FAT16 - 28'd1));
    rows.push_back(mk(28'd256, 2'd0, fel_pkg::EOC_FAT16));
    foreach (rows[i]) issue(rows[i].cl, rows[i].cp, rows[i].val, 1'b1);
    random_batch(200);

    // FAT32 volume from the long FAT size, 4096-byte sectors.
    set_geometry(4096, 8, 32, 2, 0, 0, 32'h0001_0000, 32'hFFFF_FFFF);
    rows = {};
    rows.push_back(mk(28'd1023, 2'd1, fel_pkg::EOC_THR_FAT32));
    rows.push_back(mk(28'd1024, 2'd2, fel_pkg::EOC_THR_FAT32 - 28'd1));
    foreach (rows[i]) issue(rows[i].cl, rows[i].cp, rows[i].val, 1'b1);
    random_batch(200);

    // Metadata beyond the volume, maximal registers everywhere but the total size.
    set_geometry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd100);
    random_batch(150);

    // Zero sector size and zero cluster size.
    set_geometry(0, 0, 1, 1, 0, 0, 9, 1000);
    random_batch(150);

    // Oversized sector field with offsets past 4095, short FAT size 0.
    set_geometry(8191, 128, 1, 4, 65535, 0, 0, 32'h0800_0000);
    random_batch(150);

    // Random geometries, legal sizes, between phases.
    for (int k = 0; k < 6; k++) begin
      set_geometry(512 << $urandom_range(0, 3), 1 << $urandom_range(0, 7),
                   $urandom_range(1, 64), $urandom_range(1, 4),
                   ($urandom_range(0, 1) != 0) ? 512 : 0,
                   ($urandom_range(0, 1) != 0) ? $urandom_range(1, 65535) : 0,
                   $urandom_range(1, 1 << 20), $urandom());
      random_batch(60);
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS fat_entry_locator");
    end else begin
      $display("FAIL fat_entry_locator");
    end
    $finish;
  end
endmodule

### fat_entry_locator.f
hdl/fel_pkg.sv
hdl/fel_cfg.sv
hdl/fel_div.sv
hdl/fat_entry_locator.sv
hdl/fel_checker.sv
verif/tb_fat_entry_locator.sv
